/* sv/tcb_spline_evaluator_defines.svh */
// assertion macros for the spline evaluator
// expects clk and rst_n in the scope where a macro is used
`ifndef TCB_SPLINE_EVALUATOR_DEFINES_SVH
`define TCB_SPLINE_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TCB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tcb_pkg.sv */
// shared widths, constants and types for the spline evaluator
// no dependencies
package tcb_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned T_W        = 17;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_STAGES = 8;

  // tangent weights
  localparam int unsigned FAC_W     = COEF_W + 1;
  localparam int unsigned PAIR_W    = 2 * FAC_W;
  localparam int unsigned TRIP_W    = 3 * FAC_W;
  localparam int unsigned TRIPX_W   = TRIP_W + 1;
  localparam int unsigned WGT_SHIFT = 29;
  localparam int unsigned WGT_W     = 19;

  // tangents
  localparam int unsigned DIF_W     = VAL_W + 1;
  localparam int unsigned TPROD_W   = WGT_W + DIF_W;
  localparam int unsigned TSUM_W    = TPROD_W + 2;
  localparam int unsigned TAN_SHIFT = 14;
  localparam int unsigned TAN_W     = 37;

  // hermite basis
  localparam int unsigned FRAC_T  = 16;
  localparam int unsigned T2_W    = 2 * T_W;
  localparam int unsigned T3_W    = 3 * T_W;
  localparam int unsigned POLY_W  = T3_W + 4;
  localparam int unsigned H_SHIFT = 28;
  localparam int unsigned H_W     = 25;

  // blend
  localparam int unsigned HP_W      = H_W + VAL_W;
  localparam int unsigned HM_W      = H_W + TAN_W;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned OUT_SHIFT = 20;

  localparam logic signed [FAC_W-1:0]   Q14_ONE = FAC_W'(16384);
  localparam logic signed [TRIPX_W-1:0] WGT_RND = TRIPX_W'(1) << (WGT_SHIFT - 1);
  localparam logic signed [TSUM_W-1:0]  TAN_RND = TSUM_W'(1) << (TAN_SHIFT - 1);
  localparam logic signed [TSUM_W-1:0]  TAN_HI  =
    {{(TSUM_W - TAN_W + 1){1'b0}}, {(TAN_W - 1){1'b1}}};
  localparam logic signed [TSUM_W-1:0]  TAN_LO  =
    {{(TSUM_W - TAN_W + 1){1'b1}}, {(TAN_W - 1){1'b0}}};
  localparam logic signed [POLY_W-1:0]  ONE_Q48 = POLY_W'(1) << (3 * FRAC_T);
  localparam logic signed [POLY_W-1:0]  H_RND   = POLY_W'(1) << (H_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]   OUT_RND = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]   SAT_HI  =
    {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0]   SAT_LO  =
    {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_MODE,
    REG_TENSION_IN,
    REG_BIAS_IN,
    REG_CONTINUITY_IN,
    REG_TENSION_OUT,
    REG_BIAS_OUT,
    REG_CONTINUITY_OUT
  } cfg_idx_t;

  typedef enum logic {
    MODE_KB,
    MODE_HERMITE
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [COEF_W-1:0] tension_in;
    logic signed [COEF_W-1:0] bias_in;
    logic signed [COEF_W-1:0] continuity_in;
    logic signed [COEF_W-1:0] tension_out;
    logic signed [COEF_W-1:0] bias_out;
    logic signed [COEF_W-1:0] continuity_out;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] c;
    logic signed [VAL_W-1:0] d;
  } vals_t;

  // one advance strobe per pipeline register stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } pipe_ctl_t;

endpackage

/* sv/tcb_if.sv */
// valid/ready channel interfaces: input items, results, config writes
// depends on tcb_pkg
interface tcb_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tcb_pkg::VAL_W-1:0]  val_a;
  logic signed [tcb_pkg::VAL_W-1:0]  val_b;
  logic signed [tcb_pkg::VAL_W-1:0]  val_c;
  logic signed [tcb_pkg::VAL_W-1:0]  val_d;
  logic        [tcb_pkg::T_W-1:0]    param_t;

  modport source (output valid, val_a, val_b, val_c, val_d, param_t, input ready);
  modport sink   (input valid, val_a, val_b, val_c, val_d, param_t, output ready);
endinterface

interface tcb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tcb_pkg::VAL_W-1:0]  value;
  logic                              overflowed;

  modport source (output valid, value, overflowed, input ready);
  modport sink   (input valid, value, overflowed, output ready);
endinterface

interface tcb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tcb_pkg::IDX_W-1:0]         index;
  logic [tcb_pkg::COEF_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tcb_spline_evaluator.sv */
// top level of the spline evaluator: config registers, valid chain, datapath
// depends on tcb_pkg, the channel interfaces, tcb_cfg, tcb_basis, tcb_tangent, tcb_blend
`include "tcb_spline_evaluator_defines.svh"

// Evaluates one axis of a Kochanek-Bartels or plain Hermite cubic segment per item
// and takes one item every cycle unless the pipe is stalled. Each item passes through
// eight register stages: weight pair product, triple product and basis t^3, weight
// rounding and basis polynomials, tangent products, tangent sums with mode select,
// basis-times-operand products, pair sums, and final rounding with saturation into
// the output register. in_ch.ready drops only when all eight stages hold items and
// the output is not taken; empty stages close up during a stall. Config writes are
// taken every cycle and must only be issued while no item is in flight.
module tcb_spline_evaluator (
  input  logic       clk,
  input  logic       rst_n,
  tcb_in_if.sink     in_ch,
  tcb_out_if.source  out_ch,
  tcb_cfg_if.sink    cfg_ch
);

  localparam int unsigned LAST = tcb_pkg::NUM_STAGES - 1;

  tcb_pkg::cfg_regs_t             regs;
  tcb_pkg::pipe_ctl_t             ctl;
  tcb_pkg::vals_t                 vals_in;
  logic [tcb_pkg::NUM_STAGES-1:0] vld_r, vld_nxt;

  logic signed [tcb_pkg::H_W-1:0]   basis_h [4];
  logic signed [tcb_pkg::VAL_W-1:0] seg_p0, seg_p1;
  logic signed [tcb_pkg::TAN_W-1:0] seg_m0, seg_m1;
  logic                             seg_ovf;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    ctl.adv[LAST] = !vld_r[LAST] || out_ch.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      ctl.adv[k] = !vld_r[k] || ctl.adv[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = ctl.adv[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k <= LAST; k++) begin
      vld_nxt[k] = ctl.adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    vals_in.a = in_ch.val_a;
    vals_in.b = in_ch.val_b;
    vals_in.c = in_ch.val_c;
    vals_in.d = in_ch.val_d;
  end

  assign in_ch.ready  = ctl.adv[0];
  assign out_ch.valid = vld_r[LAST];

  tcb_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  tcb_basis u_basis (
    .clk     (clk),
    .ctl     (ctl),
    .param_t (in_ch.param_t),
    .h       (basis_h)
  );

  tcb_tangent u_tangent (
    .clk     (clk),
    .ctl     (ctl),
    .regs    (regs),
    .vals    (vals_in),
    .p0      (seg_p0),
    .p1      (seg_p1),
    .m0      (seg_m0),
    .m1      (seg_m1),
    .tan_ovf (seg_ovf)
  );

  tcb_blend u_blend (
    .clk        (clk),
    .ctl        (ctl),
    .h          (basis_h),
    .p0         (seg_p0),
    .p1         (seg_p1),
    .m0         (seg_m0),
    .m1         (seg_m1),
    .tan_ovf    (seg_ovf),
    .value      (out_ch.value),
    .overflowed (out_ch.overflowed)
  );

  `TCB_ASSERT_IMPL(a_full_blocks_input, (&vld_r) && !out_ch.ready, !in_ch.ready, "input open while pipe full and output stalled")
  `TCB_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, vld_r[0], "accepted item missing from first stage")
  `TCB_ASSERT_NEXT(a_bubble_drains, out_ch.valid && out_ch.ready && !vld_r[LAST-1], !out_ch.valid, "result repeated after hand-off")

endmodule

/* sv/tcb_cfg.sv */
// configuration register file: mode and the six tension/bias/continuity values
// depends on tcb_pkg and tcb_cfg_if
module tcb_cfg (
  input  logic                clk,
  input  logic                rst_n,
  tcb_cfg_if.sink             cfg_ch,
  output tcb_pkg::cfg_regs_t  regs
);

  tcb_pkg::cfg_regs_t regs_r, regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tcb_pkg::REG_MODE:           regs_nxt.mode = tcb_pkg::mode_t'(cfg_ch.data[0]);
        tcb_pkg::REG_TENSION_IN:     regs_nxt.tension_in     = $signed(cfg_ch.data);
        tcb_pkg::REG_BIAS_IN:        regs_nxt.bias_in        = $signed(cfg_ch.data);
        tcb_pkg::REG_CONTINUITY_IN:  regs_nxt.continuity_in  = $signed(cfg_ch.data);
        tcb_pkg::REG_TENSION_OUT:    regs_nxt.tension_out    = $signed(cfg_ch.data);
        tcb_pkg::REG_BIAS_OUT:       regs_nxt.bias_out       = $signed(cfg_ch.data);
        tcb_pkg::REG_CONTINUITY_OUT: regs_nxt.continuity_out = $signed(cfg_ch.data);
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

/* sv/tcb_basis.sv */
// hermite basis generator: t^2, t^3, the four cubic polynomials, rounding to Q20
// depends on tcb_pkg; results land in stage 5 to line up with the tangents
module tcb_basis (
  input  logic                            clk,
  input  tcb_pkg::pipe_ctl_t              ctl,
  input  logic [tcb_pkg::T_W-1:0]         param_t,
  output logic signed [tcb_pkg::H_W-1:0]  h [4]   // h00, h10, h11, h01
);

  logic [tcb_pkg::T_W-1:0]          t_s1_r, t_s2_r;
  logic [tcb_pkg::T2_W-1:0]         t2_s1_r, t2_s2_r;
  logic [tcb_pkg::T3_W-1:0]         t3_s2_r;
  logic signed [tcb_pkg::POLY_W-1:0] poly_s3_r [4];
  logic signed [tcb_pkg::H_W-1:0]    h_s4_r [4];
  logic signed [tcb_pkg::H_W-1:0]    h_s5_r [4];

  logic signed [tcb_pkg::POLY_W-1:0] t2q, t3q, tq;
  logic signed [tcb_pkg::POLY_W-1:0] poly_nxt [4];
  logic signed [tcb_pkg::POLY_W-1:0] hr [4];

  // everything in Q48
  always_comb begin
    t2q = tcb_pkg::POLY_W'(t2_s2_r) << tcb_pkg::FRAC_T;
    t3q = tcb_pkg::POLY_W'(t3_s2_r);
    tq  = tcb_pkg::POLY_W'(t_s2_r) << (2 * tcb_pkg::FRAC_T);
    poly_nxt[0] = (t3q <<< 1) - (t2q <<< 1) - t2q + tcb_pkg::ONE_Q48;
    poly_nxt[1] = t3q - (t2q <<< 1) + tq;
    poly_nxt[2] = t3q - t2q;
    poly_nxt[3] = (t2q <<< 1) + t2q - (t3q <<< 1);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hr[i] = (poly_s3_r[i] + tcb_pkg::H_RND) >>> tcb_pkg::H_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      t_s1_r  <= param_t;
      t2_s1_r <= tcb_pkg::T2_W'(param_t) * tcb_pkg::T2_W'(param_t);
    end
    if (ctl.adv[1]) begin
      t_s2_r  <= t_s1_r;
      t2_s2_r <= t2_s1_r;
      t3_s2_r <= tcb_pkg::T3_W'(t2_s1_r) * tcb_pkg::T3_W'(t_s1_r);
    end
    for (int i = 0; i < 4; i++) begin
      if (ctl.adv[2]) poly_s3_r[i] <= poly_nxt[i];
      if (ctl.adv[3]) h_s4_r[i]    <= tcb_pkg::H_W'(hr[i]);
      if (ctl.adv[4]) h_s5_r[i]    <= h_s4_r[i];
    end
  end

  assign h = h_s5_r;

endmodule

/* sv/tcb_tangent.sv */
// segment operand path: tangent weights, tangent products and sums, mode select
// depends on tcb_pkg; produces p0, p1, m0, m1 in stage 5
module tcb_tangent (
  input  logic                              clk,
  input  tcb_pkg::pipe_ctl_t                ctl,
  input  tcb_pkg::cfg_regs_t                regs,
  input  tcb_pkg::vals_t                    vals,
  output logic signed [tcb_pkg::VAL_W-1:0]  p0,
  output logic signed [tcb_pkg::VAL_W-1:0]  p1,
  output logic signed [tcb_pkg::TAN_W-1:0]  m0,
  output logic signed [tcb_pkg::TAN_W-1:0]  m1,
  output logic                              tan_ovf
);

  // weight order: ws0, ws1, we0, we1
  logic signed [tcb_pkg::FAC_W-1:0]   f_ti, f_bpi, f_bmi, f_cpi, f_cmi;
  logic signed [tcb_pkg::FAC_W-1:0]   f_to, f_bpo, f_bmo, f_cpo, f_cmo;
  logic signed [tcb_pkg::PAIR_W-1:0]  pair_s1_r [4];
  logic signed [tcb_pkg::FAC_W-1:0]   third_s1_r [4];
  logic signed [tcb_pkg::TRIP_W-1:0]  trip_s2_r [4];
  logic signed [tcb_pkg::TRIPX_W-1:0] wr [4];
  logic signed [tcb_pkg::WGT_W-1:0]   w_s3_r [4];
  logic signed [tcb_pkg::TPROD_W-1:0] tprod_s4_r [4];

  logic signed [tcb_pkg::DIF_W-1:0]   dif_s1_r [3];
  logic signed [tcb_pkg::DIF_W-1:0]   dif_s2_r [3];
  logic signed [tcb_pkg::DIF_W-1:0]   dif_s3_r [3];
  tcb_pkg::vals_t                     vals_s1_r, vals_s2_r, vals_s3_r, vals_s4_r;

  logic signed [tcb_pkg::TSUM_W-1:0]  tsum [2];
  logic signed [tcb_pkg::TSUM_W-1:0]  tclamp [2];
  logic                               tovf [2];

  logic signed [tcb_pkg::VAL_W-1:0]   p0_nxt, p1_nxt;
  logic signed [tcb_pkg::TAN_W-1:0]   m0_nxt, m1_nxt;
  logic                               ovf_nxt;

  logic signed [tcb_pkg::VAL_W-1:0]   p0_r, p1_r;
  logic signed [tcb_pkg::TAN_W-1:0]   m0_r, m1_r;
  logic                               ovf_r;

  always_comb begin
    f_ti  = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.tension_in));
    f_bpi = tcb_pkg::Q14_ONE + tcb_pkg::FAC_W'($signed(regs.bias_in));
    f_bmi = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.bias_in));
    f_cpi = tcb_pkg::Q14_ONE + tcb_pkg::FAC_W'($signed(regs.continuity_in));
    f_cmi = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.continuity_in));
    f_to  = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.tension_out));
    f_bpo = tcb_pkg::Q14_ONE + tcb_pkg::FAC_W'($signed(regs.bias_out));
    f_bmo = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.bias_out));
    f_cpo = tcb_pkg::Q14_ONE + tcb_pkg::FAC_W'($signed(regs.continuity_out));
    f_cmo = tcb_pkg::Q14_ONE - tcb_pkg::FAC_W'($signed(regs.continuity_out));
  end

  // half of the triple product, rounded back to Q14
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wr[i] = (tcb_pkg::TRIPX_W'(trip_s2_r[i]) + tcb_pkg::WGT_RND) >>> tcb_pkg::WGT_SHIFT;
    end
  end

  // Q30 tangent sums rounded to Q21.16, clamped to the 37 bit range
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tsum[i] = (tcb_pkg::TSUM_W'(tprod_s4_r[2*i]) + tcb_pkg::TSUM_W'(tprod_s4_r[2*i+1])
                 + tcb_pkg::TAN_RND) >>> tcb_pkg::TAN_SHIFT;
      tovf[i]   = 1'b0;
      tclamp[i] = tsum[i];
      if (tsum[i] > tcb_pkg::TAN_HI) begin
        tclamp[i] = tcb_pkg::TAN_HI;
        tovf[i]   = 1'b1;
      end else if (tsum[i] < tcb_pkg::TAN_LO) begin
        tclamp[i] = tcb_pkg::TAN_LO;
        tovf[i]   = 1'b1;
      end
    end
  end

  always_comb begin
    if (regs.mode == tcb_pkg::MODE_HERMITE) begin
      p0_nxt  = $signed(vals_s4_r.a);
      p1_nxt  = $signed(vals_s4_r.b);
      m0_nxt  = tcb_pkg::TAN_W'($signed(vals_s4_r.c));
      m1_nxt  = tcb_pkg::TAN_W'($signed(vals_s4_r.d));
      ovf_nxt = 1'b0;
    end else begin
      p0_nxt  = $signed(vals_s4_r.b);
      p1_nxt  = $signed(vals_s4_r.c);
      m0_nxt  = tcb_pkg::TAN_W'(tclamp[0]);
      m1_nxt  = tcb_pkg::TAN_W'(tclamp[1]);
      ovf_nxt = tovf[0] | tovf[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      pair_s1_r[0]  <= tcb_pkg::PAIR_W'(f_ti) * tcb_pkg::PAIR_W'(f_bpi);
      pair_s1_r[1]  <= tcb_pkg::PAIR_W'(f_ti) * tcb_pkg::PAIR_W'(f_bmi);
      pair_s1_r[2]  <= tcb_pkg::PAIR_W'(f_to) * tcb_pkg::PAIR_W'(f_bpo);
      pair_s1_r[3]  <= tcb_pkg::PAIR_W'(f_to) * tcb_pkg::PAIR_W'(f_bmo);
      third_s1_r[0] <= f_cmi;
      third_s1_r[1] <= f_cpi;
      third_s1_r[2] <= f_cpo;
      third_s1_r[3] <= f_cmo;
      dif_s1_r[0]   <= tcb_pkg::DIF_W'($signed(vals.b)) - tcb_pkg::DIF_W'($signed(vals.a));
      dif_s1_r[1]   <= tcb_pkg::DIF_W'($signed(vals.c)) - tcb_pkg::DIF_W'($signed(vals.b));
      dif_s1_r[2]   <= tcb_pkg::DIF_W'($signed(vals.d)) - tcb_pkg::DIF_W'($signed(vals.c));
      vals_s1_r     <= vals;
    end
    if (ctl.adv[1]) begin
      for (int i = 0; i < 4; i++) begin
        trip_s2_r[i] <= tcb_pkg::TRIP_W'(pair_s1_r[i]) * tcb_pkg::TRIP_W'(third_s1_r[i]);
      end
      dif_s2_r  <= dif_s1_r;
      vals_s2_r <= vals_s1_r;
    end
    if (ctl.adv[2]) begin
      for (int i = 0; i < 4; i++) begin
        w_s3_r[i] <= tcb_pkg::WGT_W'(wr[i]);
      end
      dif_s3_r  <= dif_s2_r;
      vals_s3_r <= vals_s2_r;
    end
    if (ctl.adv[3]) begin
      tprod_s4_r[0] <= tcb_pkg::TPROD_W'(w_s3_r[0]) * tcb_pkg::TPROD_W'(dif_s3_r[0]);
      tprod_s4_r[1] <= tcb_pkg::TPROD_W'(w_s3_r[1]) * tcb_pkg::TPROD_W'(dif_s3_r[1]);
      tprod_s4_r[2] <= tcb_pkg::TPROD_W'(w_s3_r[2]) * tcb_pkg::TPROD_W'(dif_s3_r[1]);
      tprod_s4_r[3] <= tcb_pkg::TPROD_W'(w_s3_r[3]) * tcb_pkg::TPROD_W'(dif_s3_r[2]);
      vals_s4_r     <= vals_s3_r;
    end
    if (ctl.adv[4]) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      m0_r  <= m0_nxt;
      m1_r  <= m1_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign p0      = p0_r;
  assign p1      = p1_r;
  assign m0      = m0_r;
  assign m1      = m1_r;
  assign tan_ovf = ovf_r;

endmodule

/* sv/tcb_blend.sv */
// blend stages: basis times operands, adder tree, rounding and 32 bit saturation
// depends on tcb_pkg; the last register here is the output register
module tcb_blend (
  input  logic                              clk,
  input  tcb_pkg::pipe_ctl_t                ctl,
  input  logic signed [tcb_pkg::H_W-1:0]    h [4],   // h00, h10, h11, h01
  input  logic signed [tcb_pkg::VAL_W-1:0]  p0,
  input  logic signed [tcb_pkg::VAL_W-1:0]  p1,
  input  logic signed [tcb_pkg::TAN_W-1:0]  m0,
  input  logic signed [tcb_pkg::TAN_W-1:0]  m1,
  input  logic                              tan_ovf,
  output logic signed [tcb_pkg::VAL_W-1:0]  value,
  output logic                              overflowed
);

  logic signed [tcb_pkg::HP_W-1:0]  pp0_s6_r, pp1_s6_r;
  logic signed [tcb_pkg::HM_W-1:0]  pm0_s6_r, pm1_s6_r;
  logic                             ovf_s6_r, ovf_s7_r, ovf_s8_r;
  logic signed [tcb_pkg::ACC_W-1:0] sp_s7_r, sm_s7_r;
  logic signed [tcb_pkg::ACC_W-1:0] acc;
  logic signed [tcb_pkg::ACC_W-1:0] sat;
  logic                             sat_ovf;
  logic signed [tcb_pkg::VAL_W-1:0] value_r;

  // Q36 sum to Q16, then clamp
  always_comb begin
    acc     = (sp_s7_r + sm_s7_r + tcb_pkg::OUT_RND) >>> tcb_pkg::OUT_SHIFT;
    sat     = acc;
    sat_ovf = 1'b0;
    if (acc > tcb_pkg::SAT_HI) begin
      sat     = tcb_pkg::SAT_HI;
      sat_ovf = 1'b1;
    end else if (acc < tcb_pkg::SAT_LO) begin
      sat     = tcb_pkg::SAT_LO;
      sat_ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[5]) begin
      pp0_s6_r <= tcb_pkg::HP_W'(h[0]) * tcb_pkg::HP_W'(p0);
      pp1_s6_r <= tcb_pkg::HP_W'(h[3]) * tcb_pkg::HP_W'(p1);
      pm0_s6_r <= tcb_pkg::HM_W'(h[1]) * tcb_pkg::HM_W'(m0);
      pm1_s6_r <= tcb_pkg::HM_W'(h[2]) * tcb_pkg::HM_W'(m1);
      ovf_s6_r <= tan_ovf;
    end
    if (ctl.adv[6]) begin
      sp_s7_r  <= tcb_pkg::ACC_W'(pp0_s6_r) + tcb_pkg::ACC_W'(pp1_s6_r);
      sm_s7_r  <= tcb_pkg::ACC_W'(pm0_s6_r) + tcb_pkg::ACC_W'(pm1_s6_r);
      ovf_s7_r <= ovf_s6_r;
    end
    if (ctl.adv[7]) begin
      value_r  <= tcb_pkg::VAL_W'(sat);
      ovf_s8_r <= ovf_s7_r | sat_ovf;
    end
  end

  assign value      = value_r;
  assign overflowed = ovf_s8_r;

endmodule
